// File: src/gpm_pkg.sv
// Package for the grid plant model: sizes, config and item types, sequencer states,
// and the quarter-wave sine table built at elaboration.
// No dependencies.
`default_nettype none

package gpm_pkg;

  // Delay line, battery validity and sine addressing
  localparam int LAG_DEPTH      = 2;
  localparam int LAG_SLOT_BITS  = (LAG_DEPTH > 1) ? $clog2(LAG_DEPTH) : 1;
  localparam int INVALID_CYCLE  = 24;
  localparam int INVALID_POLLS  = 2;
  localparam int POLL_BITS      = $clog2(INVALID_CYCLE);
  localparam int SINE_ADDR_BITS = 10;
  localparam int QSTEP_BITS     = SINE_ADDR_BITS - 2;
  localparam int QSTEPS         = 1 << QSTEP_BITS;
  localparam logic [15:0] SINE_PEAK = 16'd32768;

  // Power words
  localparam int PWR_BITS = 21;
  localparam int SUM_BITS = 24;
  localparam int MAG_BITS = 20;

  // Ramp step = floor(rate * dt * 16 / 1000) = floor(2 * rate * dt / 125)
  localparam int RAMP_DIV          = 125;
  localparam int RAMP_RECIP_SHIFT  = 36;
  localparam logic [29:0] RAMP_RECIP =
    30'((64'd1 << RAMP_RECIP_SHIFT) / RAMP_DIV + 64'd1);
  // Any step of at least 2^21 covers every possible draw error
  localparam logic [32:0] RAMP_SAT_LIMIT = 33'(RAMP_DIV * (1 << PWR_BITS));
  localparam logic [21:0] RAMP_SAT_STEP  = 22'(1 << PWR_BITS);

  // Queue between front and back (power-of-two depth, pointers wrap)
  localparam int QUEUE_DEPTH    = 2;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    CFG_HOUSE_LOAD  = 3'd0,
    CFG_PV_BASE     = 3'd1,
    CFG_SLOW_AMP    = 3'd2,
    CFG_SLOW_STEP   = 3'd3,
    CFG_FAST_AMP    = 3'd4,
    CFG_FAST_STEP   = 3'd5,
    CFG_RAMP_RATE   = 3'd6,
    CFG_MAINS_VOLTS = 3'd7
  } gpm_cfg_idx_e;

  typedef struct packed {
    logic [15:0] house_load_w;
    logic [15:0] pv_base_w;
    logic [14:0] slow_cloud_amp_w;
    logic [31:0] slow_phase_step;
    logic [14:0] fast_cloud_amp_w;
    logic [31:0] fast_phase_step;
    logic [15:0] ramp_rate_w_per_s;
    logic [8:0]  mains_voltage_v;
  } gpm_cfg_t;

  typedef struct packed {
    logic        first;
    logic [15:0] elapsed_ms;
    logic [15:0] commanded_draw_w;
  } gpm_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_RECIP,
    ST_SINE,
    ST_CLOUD,
    ST_SUM
  } gpm_state_e;

  typedef logic [QSTEPS-1:0][15:0] sine_lut_t;

  // Q15 quarter-wave magnitude for quarter addresses 0 .. QSTEPS-1
  function automatic sine_lut_t build_sine_lut();
    sine_lut_t   lut;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    for (int a = 0; a < QSTEPS; a++) begin
      x      = 64'(a) << (17 - SINE_ADDR_BITS);
      x2     = (x * x) >> 15;
      t      = 64'd42047 - ((x2 * 64'd4640) >> 15);
      t      = 64'd102944 - ((x2 * t) >> 15);
      lut[a] = 16'((x * t) >> 16);
    end
    return lut;
  endfunction

  localparam sine_lut_t SINE_LUT = build_sine_lut();

endpackage

`default_nettype wire

// File: src/grid_plant_model_lag_cloud.sv
// Top level of the grid plant model with vehicle ramp, cloud modulation and meter lag.
// Depends on gpm_pkg, gpm_front, gpm_queue and gpm_back.
//
// Usage:
//   Each transfer on the slave stream is one meter poll: tdata[15:0] is the time
//   since the previous poll in ms (ignored on the first poll), tdata[31:16] the
//   commanded vehicle draw in W. Each poll yields exactly one transfer on the
//   master stream: delayed grid power in 1/16 W, the mains voltage, and a
//   battery-valid flag in tuser.
//   The configuration port writes one register per cycle with cfg_we_i high;
//   write only while no poll is in flight.
// Sequencing:
//   The back end takes one poll at a time and finishes it before popping the
//   next; its sequencer steps through the ramp multiply, reciprocal multiply
//   for the ramp step, sine lookup, amplitude multiply, then the power sum.
//   A two-entry queue keeps taking polls while the back end works or while a
//   result waits in the output register.
// Reset:
//   rst_ni clears the vehicle draw, both cloud phases, the lag slot, the poll
//   counter and the queue, and loads the default register values. When the
//   receiver stalls, the result holds in the output register and the back end
//   waits in its last step; the queue fills and then tready drops.
`default_nettype none

module grid_plant_model_lag_cloud
  import gpm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i,
  // Poll stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,   // [15:0] elapsed_ms, [31:16] commanded_draw_w
  // Result stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,   // [20:0] grid_power_sixteenths, [29:21] voltage_v
  output logic             m_axis_tuser_o    // [0] battery_valid
);

  gpm_cfg_t  cfg_q;
  gpm_item_t front_item;
  gpm_item_t queue_item;
  logic      queue_full;
  logic      queue_valid;
  logic      push;
  logic      pop;

  // Register file; defaults match the plant's nominal setup
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.house_load_w      <= 16'd800;
      cfg_q.pv_base_w         <= 16'd3800;
      cfg_q.slow_cloud_amp_w  <= 15'd1200;
      cfg_q.slow_phase_step   <= 32'd252645;
      cfg_q.fast_cloud_amp_w  <= 15'd600;
      cfg_q.fast_phase_step   <= 32'd681741;
      cfg_q.ramp_rate_w_per_s <= 16'd480;
      cfg_q.mains_voltage_v   <= 9'd240;
    end else if (cfg_we_i) begin
      case (gpm_cfg_idx_e'(cfg_idx_i))
        CFG_HOUSE_LOAD:  cfg_q.house_load_w      <= cfg_wdata_i[15:0];
        CFG_PV_BASE:     cfg_q.pv_base_w         <= cfg_wdata_i[15:0];
        CFG_SLOW_AMP:    cfg_q.slow_cloud_amp_w  <= cfg_wdata_i[14:0];
        CFG_SLOW_STEP:   cfg_q.slow_phase_step   <= cfg_wdata_i;
        CFG_FAST_AMP:    cfg_q.fast_cloud_amp_w  <= cfg_wdata_i[14:0];
        CFG_FAST_STEP:   cfg_q.fast_phase_step   <= cfg_wdata_i;
        CFG_RAMP_RATE:   cfg_q.ramp_rate_w_per_s <= cfg_wdata_i[15:0];
        CFG_MAINS_VOLTS: cfg_q.mains_voltage_v   <= cfg_wdata_i[8:0];
        default: ;
      endcase
    end
  end

  // Accept polls and tag the first one
  gpm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid_i),
    .s_tready_o   (s_axis_tready_o),
    .s_tdata_i    (s_axis_tdata_i),
    .queue_full_i (queue_full),
    .push_o       (push),
    .item_o       (front_item)
  );

  // Decouple acceptance from the arithmetic
  gpm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (queue_full),
    .valid_o (queue_valid),
    .pop_i   (pop),
    .item_o  (queue_item)
  );

  // Advance the plant one poll at a time and hold the result for the receiver
  gpm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (queue_valid),
    .item_i       (queue_item),
    .pop_o        (pop),
    .m_tvalid_o   (m_axis_tvalid_o),
    .m_tready_i   (m_axis_tready_i),
    .m_tdata_o    (m_axis_tdata_o),
    .m_tuser_o    (m_axis_tuser_o)
  );

endmodule

`default_nettype wire

// File: src/gpm_front.sv
// Front end of the grid plant model: accepts polls and tags the first one.
// Depends on gpm_pkg.
`default_nettype none

module gpm_front
  import gpm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid_i,
  output logic             s_tready_o,
  input  wire logic [31:0] s_tdata_i,
  input  wire logic        queue_full_i,
  output logic             push_o,
  output gpm_item_t        item_o
);

  logic seen_q;
  logic seen_d;

  assign s_tready_o = !queue_full_i;
  assign push_o     = s_tvalid_i && !queue_full_i;

  // Elapsed time counts as zero on the very first poll
  always_comb begin
    item_o.first            = !seen_q;
    item_o.elapsed_ms       = seen_q ? s_tdata_i[15:0] : 16'd0;
    item_o.commanded_draw_w = s_tdata_i[31:16];
    seen_d                  = seen_q | push_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else begin
      seen_q <= seen_d;
    end
  end

endmodule

`default_nettype wire

// File: src/gpm_queue.sv
// Short queue of tagged polls between the front end and the back end.
// Depends on gpm_pkg.
`default_nettype none

module gpm_queue
  import gpm_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire gpm_item_t  item_i,
  output logic            full_o,
  output logic            valid_o,
  input  wire logic       pop_i,
  output gpm_item_t       item_o
);

  gpm_item_t                 mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr_q;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr_q;
  logic [QUEUE_PTR_BITS:0]   count_q;

  assign full_o  = (count_q == (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/gpm_back.sv
// Back end of the grid plant model: ramp, cloud phases, sine lookup, power sum,
// meter delay line and output register, stepped by a small sequencer.
// Depends on gpm_pkg.
`default_nettype none

module gpm_back
  import gpm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire gpm_cfg_t    cfg_i,
  input  wire logic        item_valid_i,
  input  wire gpm_item_t   item_i,
  output logic             pop_o,
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  output logic [31:0]      m_tdata_o,
  output logic             m_tuser_o
);

  gpm_state_e state_q;
  gpm_state_e state_d;

  logic                     out_free;
  logic                     out_valid_q;
  logic [PWR_BITS-1:0]      out_power_q;
  logic [8:0]               out_volts_q;
  logic                     out_batt_q;

  logic                     first_q;
  logic [15:0]              dt_q;
  logic [15:0]              cmd_q;
  logic [31:0]              rate_dt_q;
  logic [21:0]              max_step_q;
  logic [31:0]              slow_phase_q;
  logic [31:0]              fast_phase_q;
  logic [PWR_BITS-1:0]      draw_q;
  logic [15:0]              slow_sin_q;
  logic [15:0]              fast_sin_q;
  logic                     slow_neg_q;
  logic                     fast_neg_q;
  logic [MAG_BITS-1:0]      slow_mag_q;
  logic [MAG_BITS-1:0]      fast_mag_q;
  logic [PWR_BITS-1:0]      delay_q [LAG_DEPTH];
  logic [LAG_SLOT_BITS-1:0] slot_q;
  logic [POLL_BITS-1:0]     poll_q;

  // Datapath terms
  logic [47:0]              slow_inc;
  logic [47:0]              fast_inc;
  logic [32:0]              twice_rate_dt;
  logic [57:0]              recip_prod;
  logic signed [22:0]       draw_err;
  logic signed [22:0]       step_s;
  logic signed [22:0]       draw_up;
  logic signed [22:0]       draw_dn;
  logic [30:0]              slow_amp_prod;
  logic [30:0]              fast_amp_prod;
  logic signed [SUM_BITS-1:0] slow_term;
  logic signed [SUM_BITS-1:0] fast_term;
  logic signed [SUM_BITS-1:0] pv_sum;
  logic signed [SUM_BITS-1:0] inst_sum;
  logic [PWR_BITS-1:0]      inst_sat;
  logic [15:0]              slow_sin;
  logic [15:0]              fast_sin;
  logic                     slow_neg;
  logic                     fast_neg;

  // Quarter-wave lookup: mirror odd quadrants; the caller flags the negative half
  function automatic logic [15:0] sine_mag(input logic [31:0] phase);
    logic [SINE_ADDR_BITS-1:0] idx;
    logic [QSTEP_BITS-1:0]     qpos;
    logic [QSTEP_BITS:0]       addr;
    idx  = phase[31 -: SINE_ADDR_BITS];
    qpos = idx[QSTEP_BITS-1:0];
    addr = idx[QSTEP_BITS] ? ((QSTEP_BITS + 1)'(QSTEPS) - {1'b0, qpos})
                           : {1'b0, qpos};
    return addr[QSTEP_BITS] ? SINE_PEAK : SINE_LUT[addr[QSTEP_BITS-1:0]];
  endfunction

  assign out_free   = !out_valid_q || m_tready_i;
  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {2'b00, out_volts_q, out_power_q};
  assign m_tuser_o  = out_batt_q;

  always_comb begin
    slow_inc      = cfg_i.slow_phase_step * dt_q;
    fast_inc      = cfg_i.fast_phase_step * dt_q;
    twice_rate_dt = {rate_dt_q, 1'b0};
    recip_prod    = 58'(twice_rate_dt[27:0]) * 58'(RAMP_RECIP);

    draw_err = $signed({3'b000, cmd_q, 4'b0000}) - $signed({2'b00, draw_q});
    step_s   = $signed({1'b0, max_step_q});
    draw_up  = $signed({2'b00, draw_q}) + step_s;
    draw_dn  = $signed({2'b00, draw_q}) - step_s;

    slow_sin = sine_mag(slow_phase_q);
    fast_sin = sine_mag(fast_phase_q);
    slow_neg = slow_phase_q[31];
    fast_neg = fast_phase_q[31];

    slow_amp_prod = cfg_i.slow_cloud_amp_w * slow_sin_q;
    fast_amp_prod = cfg_i.fast_cloud_amp_w * fast_sin_q;

    slow_term = slow_neg_q ? -$signed({4'b0000, slow_mag_q}) : $signed({4'b0000, slow_mag_q});
    fast_term = fast_neg_q ? -$signed({4'b0000, fast_mag_q}) : $signed({4'b0000, fast_mag_q});
    pv_sum    = $signed({4'b0000, cfg_i.pv_base_w, 4'b0000}) + slow_term + fast_term;
    inst_sum  = $signed({3'b000, draw_q}) + $signed({4'b0000, cfg_i.house_load_w, 4'b0000})
              - pv_sum;
    if (inst_sum > $signed(SUM_BITS'((1 << (PWR_BITS - 1)) - 1))) begin
      inst_sat = {1'b0, {(PWR_BITS - 1){1'b1}}};
    end else if (inst_sum < -$signed(SUM_BITS'(1 << (PWR_BITS - 1)))) begin
      inst_sat = {1'b1, {(PWR_BITS - 1){1'b0}}};
    end else begin
      inst_sat = inst_sum[PWR_BITS-1:0];
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          pop_o   = 1'b1;
          state_d = ST_MUL;
        end
      end
      ST_MUL:   state_d = ST_RECIP;
      ST_RECIP: state_d = ST_SINE;
      ST_SINE:  state_d = ST_CLOUD;
      ST_CLOUD: state_d = ST_SUM;
      ST_SUM: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Model state and output handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      slow_phase_q <= '0;
      fast_phase_q <= '0;
      draw_q       <= '0;
      slot_q       <= '0;
      poll_q       <= '0;
    end else begin
      if ((state_q == ST_SUM) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_MUL:   slow_phase_q <= slow_phase_q + slow_inc[31:0];
        ST_RECIP: fast_phase_q <= fast_phase_q + fast_inc[31:0];
        ST_SINE: begin
          if (draw_err > step_s) begin
            draw_q <= draw_up[PWR_BITS-1:0];
          end else if (draw_err < -step_s) begin
            draw_q <= draw_dn[PWR_BITS-1:0];
          end else begin
            draw_q <= {1'b0, cmd_q, 4'b0000};
          end
        end
        ST_SUM: begin
          if (out_free) begin
            slot_q <= (slot_q == LAG_SLOT_BITS'(LAG_DEPTH - 1)) ? '0 : slot_q + 1'b1;
            poll_q <= (poll_q == POLL_BITS'(INVALID_CYCLE - 1)) ? '0 : poll_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        first_q <= item_i.first;
        dt_q    <= item_i.elapsed_ms;
        cmd_q   <= item_i.commanded_draw_w;
      end
      ST_MUL: rate_dt_q <= cfg_i.ramp_rate_w_per_s * dt_q;
      ST_RECIP: begin
        if (twice_rate_dt >= RAMP_SAT_LIMIT) begin
          max_step_q <= RAMP_SAT_STEP;
        end else begin
          max_step_q <= recip_prod[RAMP_RECIP_SHIFT +: 22];
        end
      end
      ST_SINE: begin
        slow_sin_q <= slow_sin;
        fast_sin_q <= fast_sin;
        slow_neg_q <= slow_neg;
        fast_neg_q <= fast_neg;
      end
      ST_CLOUD: begin
        slow_mag_q <= slow_amp_prod[30:11];
        fast_mag_q <= fast_amp_prod[30:11];
      end
      ST_SUM: begin
        if (out_free) begin
          // Prime every tap on the first poll, then run as a ring
          if (first_q) begin
            for (int i = 0; i < LAG_DEPTH; i++) begin
              delay_q[i] <= inst_sat;
            end
            out_power_q <= inst_sat;
          end else begin
            delay_q[slot_q] <= inst_sat;
            out_power_q     <= delay_q[slot_q];
          end
          out_volts_q <= cfg_i.mains_voltage_v;
          out_batt_q  <= (poll_q >= POLL_BITS'(INVALID_POLLS));
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: verif/gpm_meter_checker.sv
// Checker for the grid plant model: watches the register port and both streams,
// predicts every meter reading and compares it with the result stream.
// Depends on gpm_pkg for sizes, the register index enum and the config struct.

module gpm_meter_checker
  import gpm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [31:0] s_axis_tdata_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [31:0] m_axis_tdata_i,
  input  logic        m_axis_tuser_i,
  input  logic        final_check_i,
  output int          open_polls_o,
  output int          fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [PWR_BITS-1:0] grid_w16;
    logic [8:0]                 volts;
    logic                       batt_ok;
  } meter_reading_t;

  localparam longint GRID_MAX = (longint'(1) << (PWR_BITS - 1)) - 1;
  localparam longint GRID_MIN = -(longint'(1) << (PWR_BITS - 1));

  // Shadow registers and plant state
  gpm_cfg_t       plant_cfg;
  longint         draw_w16;
  logic [31:0]    slow_phase;
  logic [31:0]    fast_phase;
  longint         lag_ring [LAG_DEPTH];
  int             lag_pos;
  int             poll_idx;
  bit             primed;
  bit             final_done;
  int             fail_cnt;
  meter_reading_t expected_readings [$];

  assign fail_count_o = fail_cnt;

  task automatic flag_error(input string msg);
    $display("ERROR %0t ns: %s", $time, msg);
    fail_cnt++;
  endtask

  // Signed cloud contribution in 1/16 W, quarter-wave sine mirrored and negated by quadrant
  function automatic longint cloud_w16(input logic [31:0] phase, input logic [14:0] amp);
    logic [SINE_ADDR_BITS-1:0] idx;
    logic [1:0]                quad;
    longint unsigned           a, x, x2, t, mag;
    idx  = phase[31 -: SINE_ADDR_BITS];
    quad = idx[SINE_ADDR_BITS-1 -: 2];
    a    = 64'(idx[QSTEP_BITS-1:0]);
    if (quad[0]) a = 64'(QSTEPS) - a;
    x   = a << (17 - SINE_ADDR_BITS);
    x2  = (x * x) >> 15;
    t   = 64'd42047 - ((x2 * 64'd4640) >> 15);
    t   = 64'd102944 - ((x2 * t) >> 15);
    mag = (64'(amp) * ((x * t) >> 16)) >> 11;
    return quad[1] ? -longint'(mag) : longint'(mag);
  endfunction

  // Advance the plant by one poll and return the reading it reports
  task automatic advance_plant(input logic [15:0] elapsed, input logic [15:0] cmd_w,
                               output meter_reading_t r);
    longint      dt, step, err, pv, inst, oldest, cmd16;
    logic [63:0] ph;
    dt = primed ? longint'(elapsed) : 0;
    ph = 64'(slow_phase) + 64'(plant_cfg.slow_phase_step) * 64'(dt);
    slow_phase = ph[31:0];
    ph = 64'(fast_phase) + 64'(plant_cfg.fast_phase_step) * 64'(dt);
    fast_phase = ph[31:0];

    // Vehicle draw slews toward the command, limited by rate times elapsed time
    step  = longint'(plant_cfg.ramp_rate_w_per_s) * dt * 16 / 1000;
    cmd16 = longint'(cmd_w) * 16;
    err   = cmd16 - draw_w16;
    if (err > step) draw_w16 += step;
    else if (err < -step) draw_w16 -= step;
    else draw_w16 = cmd16;

    pv = longint'(plant_cfg.pv_base_w) * 16
       + cloud_w16(slow_phase, plant_cfg.slow_cloud_amp_w)
       + cloud_w16(fast_phase, plant_cfg.fast_cloud_amp_w);
    inst = draw_w16 + longint'(plant_cfg.house_load_w) * 16 - pv;
    if (inst > GRID_MAX) inst = GRID_MAX;
    if (inst < GRID_MIN) inst = GRID_MIN;

    // First reading primes every slot of the lag line
    if (!primed) begin
      foreach (lag_ring[i]) lag_ring[i] = inst;
      primed = 1'b1;
    end
    oldest            = lag_ring[lag_pos];
    lag_ring[lag_pos] = inst;
    lag_pos           = (lag_pos + 1 >= LAG_DEPTH) ? 0 : lag_pos + 1;

    r.grid_w16 = oldest[PWR_BITS-1:0];
    r.volts    = plant_cfg.mains_voltage_v;
    r.batt_ok  = (poll_idx >= INVALID_POLLS);
    poll_idx   = (poll_idx + 1 >= INVALID_CYCLE) ? 0 : poll_idx + 1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    meter_reading_t want;
    meter_reading_t got;
    if (!rst_ni) begin
      plant_cfg.house_load_w      = 16'd800;
      plant_cfg.pv_base_w         = 16'd3800;
      plant_cfg.slow_cloud_amp_w  = 15'd1200;
      plant_cfg.slow_phase_step   = 32'd252645;
      plant_cfg.fast_cloud_amp_w  = 15'd600;
      plant_cfg.fast_phase_step   = 32'd681741;
      plant_cfg.ramp_rate_w_per_s = 16'd480;
      plant_cfg.mains_voltage_v   = 9'd240;
      draw_w16   = 0;
      slow_phase = '0;
      fast_phase = '0;
      foreach (lag_ring[i]) lag_ring[i] = 0;
      lag_pos    = 0;
      poll_idx   = 0;
      primed     = 1'b0;
      final_done = 1'b0;
      expected_readings.delete();
      open_polls_o <= 0;
    end else begin
      // Results first: nothing accepted at this edge can already be out
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.grid_w16 = m_axis_tdata_i[PWR_BITS-1:0];
        got.volts    = m_axis_tdata_i[PWR_BITS +: 9];
        got.batt_ok  = m_axis_tuser_i;
        if (expected_readings.size() == 0) begin
          flag_error($sformatf("result transfer with no poll outstanding: grid %0d",
                               got.grid_w16));
        end else begin
          want = expected_readings.pop_front();
          if (got.grid_w16 !== want.grid_w16)
            flag_error($sformatf("grid power %0d, expected %0d", got.grid_w16, want.grid_w16));
          if (got.volts !== want.volts)
            flag_error($sformatf("voltage %0d, expected %0d", got.volts, want.volts));
          if (got.batt_ok !== want.batt_ok)
            flag_error($sformatf("battery valid %b, expected %b", got.batt_ok, want.batt_ok));
        end
      end

      if (s_axis_tvalid_i && s_axis_tready_i) begin
        advance_plant(s_axis_tdata_i[15:0], s_axis_tdata_i[31:16], want);
        expected_readings.push_back(want);
      end

      if (cfg_we_i) begin
        case (gpm_cfg_idx_e'(cfg_idx_i))
          CFG_HOUSE_LOAD:  plant_cfg.house_load_w      = cfg_wdata_i[15:0];
          CFG_PV_BASE:     plant_cfg.pv_base_w         = cfg_wdata_i[15:0];
          CFG_SLOW_AMP:    plant_cfg.slow_cloud_amp_w  = cfg_wdata_i[14:0];
          CFG_SLOW_STEP:   plant_cfg.slow_phase_step   = cfg_wdata_i;
          CFG_FAST_AMP:    plant_cfg.fast_cloud_amp_w  = cfg_wdata_i[14:0];
          CFG_FAST_STEP:   plant_cfg.fast_phase_step   = cfg_wdata_i;
          CFG_RAMP_RATE:   plant_cfg.ramp_rate_w_per_s = cfg_wdata_i[15:0];
          CFG_MAINS_VOLTS: plant_cfg.mains_voltage_v   = cfg_wdata_i[8:0];
          default: ;
        endcase
      end

      if (final_check_i && !final_done) begin
        foreach (expected_readings[i])
          flag_error($sformatf("poll never answered, expected grid %0d",
                               expected_readings[i].grid_w16));
        final_done = 1'b1;
      end
      open_polls_o <= expected_readings.size();
    end
  end

endmodule

// File: verif/tb_grid_plant_model_lag_cloud.sv
// Testbench top for the grid plant model: clock, reset, register loads, poll
// stimulus and receiver pacing; the verdict comes from the checker's failure count.
// Depends on gpm_pkg, grid_plant_model_lag_cloud and gpm_meter_checker.

module tb_grid_plant_model_lag_cloud
  import gpm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [2:0]  cfg_idx    = '0;
  logic [31:0] cfg_wdata  = '0;
  logic        s_valid    = 1'b0;
  logic [31:0] s_data     = '0;
  logic        m_ready    = 1'b0;
  logic        final_check = 1'b0;
  logic        quiet_mode = 1'b0;   // no gaps and no stalls while set

  wire         s_ready;
  wire         m_valid;
  wire  [31:0] m_data;
  wire         m_user;
  int          open_polls;
  int          fail_count;

  int          stall_left;
  int          polls_sent;
  int          settings_loaded;
  logic [15:0] last_cmd;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  grid_plant_model_lag_cloud dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),     // [15:0] elapsed_ms, [31:16] commanded_draw_w
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),     // [20:0] grid_power_sixteenths, [29:21] voltage_v
    .m_axis_tuser_o  (m_user)      // [0] battery_valid
  );

  gpm_meter_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_i (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_i (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_i  (m_data),
    .m_axis_tuser_i  (m_user),
    .final_check_i   (final_check),
    .open_polls_o    (open_polls),
    .fail_count_o    (fail_count)
  );

  // Idle length: sender gaps are often zero, receiver stalls are never zero.
  // Mostly short, now and then long enough to back the queue up completely.
  function automatic int idle_len(input bit for_sink);
    int r;
    r = $urandom_range(99);
    if (!for_sink && r < 55) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Receiver pacing: hold tready low for a random stall now and then
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      m_ready <= 1'b0;
      stall_left--;
    end else begin
      m_ready <= 1'b1;
      if (!quiet_mode && $urandom_range(99) < 18) stall_left = idle_len(1'b1);
    end
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("timeout: result stream stopped making progress");
    $display("tb_grid_plant_model_lag_cloud NOT OK");
    $finish;
  end

  function automatic gpm_cfg_t plant_cfg_of(
    input logic [15:0] house, input logic [15:0] pv,
    input logic [14:0] slow_amp, input logic [31:0] slow_step,
    input logic [14:0] fast_amp, input logic [31:0] fast_step,
    input logic [15:0] rate, input logic [8:0] volts);
    gpm_cfg_t c;
    c.house_load_w      = house;
    c.pv_base_w         = pv;
    c.slow_cloud_amp_w  = slow_amp;
    c.slow_phase_step   = slow_step;
    c.fast_cloud_amp_w  = fast_amp;
    c.fast_phase_step   = fast_step;
    c.ramp_rate_w_per_s = rate;
    c.mains_voltage_v   = volts;
    return c;
  endfunction

  // Zero, all ones or random within the register width
  function automatic logic [31:0] pick_reg_value(input int width);
    logic [31:0] mask;
    int          r;
    mask = (width >= 32) ? 32'hFFFF_FFFF : ((32'd1 << width) - 32'd1);
    r = $urandom_range(5);
    if (r == 0) return '0;
    if (r == 1) return mask;
    return $urandom() & mask;
  endfunction

  // Write every register back to back; with junk set, fill the unused upper bits
  // of the write data with noise, which the block must drop.
  task automatic load_plant_cfg(input gpm_cfg_t c, input bit junk);
    gpm_cfg_idx_e ix;
    logic [31:0]  v;
    int           w;
    ix = ix.first();
    repeat (ix.num()) begin
      case (ix)
        CFG_HOUSE_LOAD:  begin v = 32'(c.house_load_w);      w = 16; end
        CFG_PV_BASE:     begin v = 32'(c.pv_base_w);         w = 16; end
        CFG_SLOW_AMP:    begin v = 32'(c.slow_cloud_amp_w);  w = 15; end
        CFG_SLOW_STEP:   begin v = c.slow_phase_step;        w = 32; end
        CFG_FAST_AMP:    begin v = 32'(c.fast_cloud_amp_w);  w = 15; end
        CFG_FAST_STEP:   begin v = c.fast_phase_step;        w = 32; end
        CFG_RAMP_RATE:   begin v = 32'(c.ramp_rate_w_per_s); w = 16; end
        default:         begin v = 32'(c.mains_voltage_v);   w = 9;  end
      endcase
      if (junk && w < 32) v = v | ($urandom() << w);
      cfg_we    <= 1'b1;
      cfg_idx   <= ix;
      cfg_wdata <= v;
      @(posedge clk_i);
      ix = ix.next();
    end
    cfg_we <= 1'b0;
    @(posedge clk_i);
    settings_loaded++;
  endtask

  // One poll transfer. Valid stays high across back-to-back polls and is only
  // lowered when a gap follows.
  task automatic send_poll(input logic [15:0] elapsed, input logic [15:0] cmd_w);
    int gap;
    gap = quiet_mode ? 0 : idle_len(1'b0);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {cmd_w, elapsed};
    do @(posedge clk_i); while (!s_ready);
    polls_sent++;
    last_cmd = cmd_w;
  endtask

  // Hold off the sender until every outstanding reading has come back, then let
  // the back end settle.
  task automatic drain_results();
    s_valid <= 1'b0;
    @(posedge clk_i);
    for (int k = 0; k < 20000 && open_polls != 0; k++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic run_random_polls(input int n, input bit pause_mid);
    logic [15:0] elapsed;
    logic [15:0] cmd_w;
    int          r;
    for (int i = 0; i < n; i++) begin
      // Elapsed time: mostly realistic poll spacing, some tiny, some full range
      r = $urandom_range(99);
      if (r < 50)      elapsed = 16'($urandom_range(0, 2000));
      else if (r < 70) elapsed = 16'($urandom_range(0, 20));
      else if (r < 90) elapsed = 16'($urandom());
      else             elapsed = ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
      // Command: jumps, extremes, or small moves around the last command
      r = $urandom_range(99);
      if (r < 40)      cmd_w = 16'($urandom());
      else if (r < 60) cmd_w = ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
      else             cmd_w = last_cmd + 16'($urandom_range(0, 400)) - 16'd200;
      send_poll(elapsed, cmd_w);
      if (pause_mid && i == n / 2) drain_results();
    end
  endtask

  initial begin
    gpm_cfg_t cfg;
    last_cmd = '0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Peak solar: both clouds a quarter turn per ms, so consecutive 1 ms polls
    // walk through all four quadrants from phase zero. The first poll's elapsed
    // time must be ignored; the quarter-turn peak drives grid power below range.
    load_plant_cfg(plant_cfg_of(16'd0, 16'hFFFF, 15'h7FFF, 32'h4000_0000,
                                15'h7FFF, 32'h4000_0000, 16'hFFFF, 9'd0), 1'b0);
    send_poll(16'hFFFF, 16'd0);
    send_poll(16'd1, 16'd0);
    send_poll(16'd1, 16'd0);
    send_poll(16'd1, 16'd0);
    send_poll(16'd1, 16'd0);
    send_poll(16'hFFFF, 16'hFFFF);
    drain_results();

    // Heavy load, no solar: grid power above range
    load_plant_cfg(plant_cfg_of(16'hFFFF, 16'd0, 15'd0, 32'd0, 15'd0, 32'd0,
                                16'hFFFF, 9'h1FF), 1'b0);
    send_poll(16'd0, 16'hFFFF);
    send_poll(16'd0, 16'hFFFF);
    drain_results();

    // Reset values: zero elapsed freezes the draw, then rate-limited ramps both ways
    load_plant_cfg(plant_cfg_of(16'd800, 16'd3800, 15'd1200, 32'd252645,
                                15'd600, 32'd681741, 16'd480, 9'd240), 1'b0);
    send_poll(16'd0, 16'd0);
    send_poll(16'hFFFF, 16'd0);
    send_poll(16'd1, 16'hFFFF);
    drain_results();

    // Every register at its top value: phase wraps on each long poll
    load_plant_cfg(plant_cfg_of(16'hFFFF, 16'hFFFF, 15'h7FFF, 32'hFFFF_FFFF,
                                15'h7FFF, 32'hFFFF_FFFF, 16'hFFFF, 9'h1FF), 1'b0);
    send_poll(16'hFFFF, 16'hFFFF);
    send_poll(16'hFFFF, 16'd0);
    send_poll(16'h8000, 16'h5555);
    drain_results();

    // Every register zero: no ramp at all
    load_plant_cfg(plant_cfg_of(16'd0, 16'd0, 15'd0, 32'd0, 15'd0, 32'd0,
                                16'd0, 9'd0), 1'b0);
    send_poll(16'd1000, 16'hAAAA);
    send_poll(16'hFFFF, 16'hFFFF);
    send_poll(16'd0, 16'd0);
    drain_results();

    // Random part: one phase per register setting, each drained before the next load
    for (int p = 0; p < 8; p++) begin
      if (p == 0) begin
        cfg = plant_cfg_of(16'd800, 16'd3800, 15'd1200, 32'd252645,
                           15'd600, 32'd681741, 16'd480, 9'd240);
      end else if (p == 1) begin
        cfg = plant_cfg_of(16'($urandom_range(0, 5000)), 16'($urandom_range(0, 8000)),
                           15'($urandom_range(0, 3000)), $urandom_range(0, 2_000_000),
                           15'($urandom_range(0, 3000)), $urandom_range(0, 2_000_000),
                           16'($urandom_range(0, 5000)), 9'($urandom_range(200, 260)));
      end else begin
        cfg = plant_cfg_of(16'(pick_reg_value(16)), 16'(pick_reg_value(16)),
                           15'(pick_reg_value(15)), pick_reg_value(32),
                           15'(pick_reg_value(15)), pick_reg_value(32),
                           16'(pick_reg_value(16)), 9'(pick_reg_value(9)));
      end
      quiet_mode <= (p == 3);
      load_plant_cfg(cfg, p >= 2);
      run_random_polls(104, p == 2);
      drain_results();
    end
    quiet_mode <= 1'b0;

    final_check <= 1'b1;
    repeat (3) @(posedge clk_i);

    $display("covered %0d polls under %0d register settings: ramp limits, cloud quadrants,",
             polls_sent, settings_loaded);
    $display("grid saturation both ways, phase wrap, lag priming and the battery-valid cycle");
    if (fail_count == 0) begin
      $display("tb_grid_plant_model_lag_cloud OK");
    end else begin
      $display("tb_grid_plant_model_lag_cloud NOT OK");
    end
    $finish;
  end

endmodule
